// ===== hw/rtl/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants for the link matrix block: sizes, the
// register map and the engine state encoding.
// ----------------------------------------------------------------------------
package lmc_pkg;

  // storage depth and derived widths
  localparam int MAX_ELEMENTS = 32;
  localparam int ROW_W        = 32;
  localparam int ROW_CAP      = (MAX_ELEMENTS < ROW_W) ? MAX_ELEMENTS : ROW_W;
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W        = 6;
  localparam int IDX_W        = 5;

  // apb register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd32;

  // engine states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_FIRST,
    ST_SQ,
    ST_OUT
  } lmc_state_e;

  // configuration handed from the register block to the engine
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             clear;
  } lmc_cfg_t;

endpackage

// ===== hw/rtl/lmc_ram.sv =====
// ----------------------------------------------------------------------------
// lmc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/lmc_engine.sv =====
// ----------------------------------------------------------------------------
// lmc_engine
// Loads causal rows into the row store, then for each row ORs together the
// stored rows its set bits select and emits the row minus that square.
// ----------------------------------------------------------------------------
module lmc_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lmc_pkg::lmc_cfg_t            cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lmc_pkg::ROW_W-1:0]    causal_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lmc_pkg::ROW_W-1:0]    link_row_o,
  output logic [lmc_pkg::IDX_W-1:0]    row_index_o,
  output logic                         last_row_o
);
  import lmc_pkg::*;

  lmc_state_e       state_q, state_d;
  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [ROW_W-1:0] cur_q, cur_d;
  logic [ROW_W-1:0] sq_q, sq_d;
  logic             out_valid_q, out_valid_d;
  logic [ROW_W-1:0] link_q, link_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_q, last_d;

  logic [ROW_W-1:0]  mask;
  logic              in_acc;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ROW_W-1:0]  mem_rdata;
  logic [CNT_W-1:0]  k_next;
  logic              row_last;

  // column mask for the active element count
  assign mask     = ~({ROW_W{1'b1}} << cfg_i.count);
  assign in_acc   = in_valid_i && in_ready_o;
  assign k_next   = k_q + 1'b1;
  assign row_last = (row_q == cfg_i.count - 1'b1);

  // row store
  assign mem_we    = in_acc;
  assign mem_waddr = loaded_q[ADDR_W-1:0];

  lmc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (causal_row_i & mask),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      loaded_q    <= '0;
      row_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      row_q       <= row_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sq_q   <= sq_d;
    link_q <= link_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  // next state and control
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    row_d       = row_q;
    k_d         = k_q;
    cur_d       = cur_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q;
    link_d      = link_q;
    idx_d       = idx_q;
    last_d      = last_q;
    in_ready_o  = 1'b0;
    mem_raddr   = row_q[ADDR_W-1:0];

    // output word taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (loaded_q + 1'b1 == cfg_i.count) begin
            loaded_d = '0;
            row_d    = '0;
            state_d  = ST_FETCH;
          end else begin
            loaded_d = loaded_q + 1'b1;
          end
        end
      end
      ST_FETCH: begin
        mem_raddr = row_q[ADDR_W-1:0];
        state_d   = ST_FIRST;
      end
      ST_FIRST: begin
        // own row arrives, start the square sweep at row zero
        cur_d     = mem_rdata;
        sq_d      = '0;
        k_d       = '0;
        mem_raddr = '0;
        state_d   = ST_SQ;
      end
      ST_SQ: begin
        if (cur_q[k_q[IDX_W-1:0]]) begin
          sq_d = sq_q | mem_rdata;
        end
        mem_raddr = k_next[ADDR_W-1:0];
        k_d       = k_next;
        if (k_next == cfg_i.count) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          link_d      = cur_q & ~sq_q & mask;
          idx_d       = row_q[IDX_W-1:0];
          last_d      = row_last;
          if (row_last) begin
            row_d   = '0;
            state_d = ST_LOAD;
          end else begin
            row_d   = row_q + 1'b1;
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // a count write drops a partly loaded matrix
    if (cfg_i.clear) begin
      loaded_d = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign link_row_o  = link_q;
  assign row_index_o = idx_q;
  assign last_row_o  = last_q;

  // checks
  a_loaded_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (loaded_q < cfg_i.count))
    else $error("load count reached element count while loading");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> (k_q < cfg_i.count))
    else $error("square sweep ran past the element count");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> ({1'b0, idx_q} == cfg_i.count - 1'b1))
    else $error("last row flag on a row other than the final one");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == ST_LOAD))
    else $error("row accepted while the square sweep runs");

endmodule

// ===== hw/rtl/link_matrix_from_causal_matrix.sv =====
// ----------------------------------------------------------------------------
// link_matrix_from_causal_matrix
// Transitive reduction of a Boolean causal matrix, one row per word.
// ----------------------------------------------------------------------------
// Rows of the causal matrix arrive one word per cycle while the block is
// loading and are written into a row RAM with one write port and one read
// port. Once element_count rows are in (n, where zero acts as one and counts
// above 32 saturate), the block emits n link rows in order, the final one
// flagged by last_row. Each link row is built by a sweep over the RAM: one
// read for the row itself, then one read per stored row to OR the square,
// so the rate is bounded by the one RAM read port. No rows are taken while
// the sweep runs. Column bits at or above n are cleared on entry.
// Writing element_count (APB, byte address 0) drops a partly loaded matrix.
module link_matrix_from_causal_matrix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lmc_pkg::APB_AW-1:0]   paddr,
  input  logic [lmc_pkg::APB_DW-1:0]   pwdata,
  output logic [lmc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lmc_pkg::ROW_W-1:0]    causal_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lmc_pkg::ROW_W-1:0]    link_row_o,
  output logic [lmc_pkg::IDX_W-1:0]    row_index_o,
  output logic                         last_row_o
);
  import lmc_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(ROW_CAP);

  logic [CNT_W-1:0] count_q, count_d;
  logic             wr_en;
  logic [CNT_W-1:0] count_eff;
  lmc_cfg_t         cfg;

  // register write decode
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  // register read
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ?
                  {{(APB_DW-CNT_W){1'b0}}, count_q} : '0;

  // effective element count
  always_comb begin
    if (count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (count_q > CAP) begin
      count_eff = CAP;
    end else begin
      count_eff = count_q;
    end
  end

  assign cfg.count = count_eff;
  assign cfg.clear = wr_en;

  lmc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .causal_row_i (causal_row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .link_row_o   (link_row_o),
    .row_index_o  (row_index_o),
    .last_row_o   (last_row_o)
  );

endmodule
